FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of the node sampler.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while the active-low reset is low.
`define GNS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that also checks during reset.
`define GNS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/gns_pkg.sv
// Shared constants, queue item type and cosine weight table of the node sampler.
// No dependencies.
`timescale 1ns / 1ps

package gns_pkg;

  localparam int MAX_SIDE       = 64;
  localparam int CELL_SIZE_LOG2 = 5;
  localparam int FRACTION_BITS  = 8;

  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int CFG_W      = 7;
  localparam int POS_W      = 24;
  localparam int POS_SHIFT  = 8 + CELL_SIZE_LOG2;
  localparam int CELL_W     = POS_W - POS_SHIFT;
  localparam int FB         = FRACTION_BITS;
  localparam int T_W        = FB + 1;
  localparam int FRAC_ONE   = 1 << FB;
  localparam int BANK_AW    = 2 * (SIDE_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int CW_W       = 17;
  localparam int CW_ONE     = 65536;
  localparam int DATA_W     = 16;
  localparam int NODE_W     = 6 * DATA_W;
  localparam int U_W        = DATA_W + FB;

  // divisors (2k-1)*(2k) of the cosine series terms
  localparam longint unsigned TAYLOR_DIV [1:12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_e;

  // One queued beat: a node write or a classified sample.
  typedef struct packed {
    logic                       is_write;
    logic [1:0]                 wr_bank;
    logic [BANK_AW-1:0]         wr_addr;
    logic [NODE_W-1:0]          wr_data;
    logic [3:0][BANK_AW-1:0]    rd_addr;
    logic                       px;
    logic                       pz;
    logic [T_W-1:0]             tx;
    logic [T_W-1:0]             tz;
    logic [CW_W-1:0]            cwx;
    logic [CW_W-1:0]            cwz;
  } gns_item_t;

  // (1-cos(pi*i/256))/2 in Q0.16 from a Q30 Taylor series
  function automatic logic [CW_W-1:0] rom_entry(int unsigned i);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint          cv;
    longint          d;
    a    = (longint'(i) * 64'd3373259426 + 64'd128) >> 8;
    a2   = (a * a) >> 30;
    term = 64'd1 << 30;
    cv   = longint'(term);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * a2) >> 30) / TAYLOR_DIV[k];
      if (k[0]) cv = cv - longint'(term);
      else      cv = cv + longint'(term);
    end
    d = (longint'(1) << 30) - cv;
    if (d < 0) d = 0;
    if (d > (longint'(1) << 31)) d = longint'(1) << 31;
    return CW_W'((d + (longint'(1) << 14)) >> 15);
  endfunction

  function automatic logic [255:0][CW_W-1:0] build_cos_rom();
    logic [255:0][CW_W-1:0] r;
    for (int i = 0; i <= 128; i++) r[i] = rom_entry(i);
    for (int i = 129; i < 256; i++) r[i] = CW_W'(CW_ONE) - r[256 - i];
    return r;
  endfunction

  localparam logic [255:0][CW_W-1:0] COS_ROM = build_cos_rom();

endpackage

FILE: hdl/gns_front.sv
// Front end: classifies an input beat, splits the sample position into cell and
// fraction, looks up cosine weights and forms per-bank addresses. Uses gns_pkg.
`timescale 1ns / 1ps

module gns_front import gns_pkg::*; (
  input  logic                op_i,
  input  logic [POS_W-1:0]    pos_x_i,
  input  logic [POS_W-1:0]    pos_z_i,
  input  logic [SIDE_W-1:0]   node_col_i,
  input  logic [SIDE_W-1:0]   node_row_i,
  input  logic [DATA_W-1:0]   node_height_i,
  input  logic [DATA_W-1:0]   node_vegetation_i,
  input  logic [DATA_W-1:0]   node_weight_0_i,
  input  logic [DATA_W-1:0]   node_weight_1_i,
  input  logic [DATA_W-1:0]   node_weight_2_i,
  input  logic [DATA_W-1:0]   node_weight_3_i,
  input  logic [CFG_W-1:0]    limit_x_i,
  input  logic [CFG_W-1:0]    limit_z_i,
  output gns_item_t           item_o
);

  typedef struct packed {
    logic [SIDE_W-1:0] cidx;
    logic [T_W-1:0]    t;
  } axis_t;

  function automatic axis_t split_axis(logic [POS_W-1:0] pos, logic [CFG_W-1:0] lim);
    logic [CELL_W-1:0]    c;
    logic [POS_SHIFT-1:0] f;
    axis_t                r;
    c = pos[POS_W-1:POS_SHIFT];
    f = pos[POS_SHIFT-1:0];
    // beyond the last cell: pin to it and saturate the fraction to one
    if (32'(c) > 32'(lim)) begin
      r.cidx = SIDE_W'(lim);
      r.t    = T_W'(FRAC_ONE);
    end else begin
      r.cidx = SIDE_W'(c);
      r.t    = T_W'({f, {FB{1'b0}}} >> POS_SHIFT);
    end
    return r;
  endfunction

  function automatic logic [CW_W-1:0] cos_weight(logic [T_W-1:0] t);
    logic [7:0] idx;
    idx = 8'({t[FB-1:0], 8'b0} >> FB);
    if (t[FB]) return CW_W'(CW_ONE);
    return COS_ROM[idx];
  endfunction

  axis_t ax;
  axis_t az;
  logic  [SIDE_W-1:0] row;
  logic  [SIDE_W-1:0] col;
  logic  [1:0]        bb;

  always_comb begin
    ax = split_axis(pos_x_i, limit_x_i);
    az = split_axis(pos_z_i, limit_z_i);

    item_o          = '0;
    item_o.is_write = (op_e'(op_i) == OP_WRITE);
    item_o.wr_bank  = {node_row_i[0], node_col_i[0]};
    item_o.wr_addr  = {node_row_i[SIDE_W-1:1], node_col_i[SIDE_W-1:1]};
    item_o.wr_data  = {node_weight_3_i, node_weight_2_i, node_weight_1_i,
                       node_weight_0_i, node_vegetation_i, node_height_i};
    item_o.px       = ax.cidx[0];
    item_o.pz       = az.cidx[0];
    item_o.tx       = ax.t;
    item_o.tz       = az.t;
    item_o.cwx      = cos_weight(ax.t);
    item_o.cwz      = cos_weight(az.t);

    // bank {row parity, col parity} holds exactly one of the four neighbors
    row = '0;
    col = '0;
    bb  = '0;
    for (int b = 0; b < 4; b++) begin
      bb  = 2'(b);
      row = az.cidx + SIDE_W'(az.cidx[0] ^ bb[1]);
      col = ax.cidx + SIDE_W'(ax.cidx[0] ^ bb[0]);
      item_o.rd_addr[b] = {row[SIDE_W-1:1], col[SIDE_W-1:1]};
    end
  end

endmodule

FILE: hdl/gns_fifo.sv
// Two-entry queue between front and back end, one push and one pop per cycle.
// Uses gns_pkg for the item type.
`timescale 1ns / 1ps

module gns_fifo import gns_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  gns_item_t item_i,
  output logic      ready_o,
  input  logic      pop_i,
  output logic      valid_o,
  output gns_item_t item_o
);

  gns_item_t  mem_q [2];
  logic       wr_ptr_q;
  logic       wr_ptr_d;
  logic       rd_ptr_q;
  logic       rd_ptr_d;
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

FILE: hdl/gns_back.sv
// Back end: four parity-banked node memories, row blend stage, column blend stage
// and output register. Uses gns_pkg.
`timescale 1ns / 1ps

module gns_back import gns_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  input  gns_item_t                item_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] out_height_o,
  output logic [DATA_W-1:0]        out_vegetation_o,
  output logic [DATA_W-1:0]        out_weight_0_o,
  output logic [DATA_W-1:0]        out_weight_1_o,
  output logic [DATA_W-1:0]        out_weight_2_o,
  output logic [DATA_W-1:0]        out_weight_3_o
);

  localparam int CH = 5;
  localparam int RND = 1 << (2 * FB - 1);

  function automatic logic [U_W-1:0] lerp_row(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                              logic [T_W-1:0] t);
    logic signed [U_W+2:0] p;
    p = ($signed({1'b0, b}) - $signed({1'b0, a})) * $signed({1'b0, t});
    p = p + $signed((U_W+3)'({a, {FB{1'b0}}}));
    return p[U_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] lerp_col(logic [U_W-1:0] a, logic [U_W-1:0] b,
                                                 logic [T_W-1:0] t);
    logic signed [U_W+FB+2:0] p;
    p = ($signed({1'b0, b}) - $signed({1'b0, a})) * $signed({1'b0, t});
    p = p + $signed((U_W+FB+3)'({a, {FB{1'b0}}})) + $signed((U_W+FB+3)'(RND));
    return p[2*FB+DATA_W-1:2*FB];
  endfunction

  function automatic logic signed [DATA_W-1:0] cos_blend(logic signed [DATA_W-1:0] a,
                                                         logic signed [DATA_W-1:0] b,
                                                         logic [CW_W-1:0] c);
    logic signed [35:0] p;
    p = ($signed({b[DATA_W-1], b}) - $signed({a[DATA_W-1], a})) * $signed({1'b0, c});
    p = p + (36'(a) <<< 16) + 36'sd32768;
    return p[31:16];
  endfunction

  logic en;
  assign en    = !out_valid_o || out_ready_i;
  assign pop_o = en && item_valid_i;

  // memories and read stage
  logic [NODE_W-1:0] rd_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [NODE_W-1:0] mem [BANK_DEPTH];
    always_ff @(posedge clk_i) begin
      if (pop_o && item_i.is_write && (item_i.wr_bank == 2'(b))) begin
        mem[item_i.wr_addr] <= item_i.wr_data;
      end
      if (en) rd_q[b] <= mem[item_i.rd_addr[b]];
    end
  end

  logic           v0_q;
  logic           v0_d;
  logic           px_q, pz_q;
  logic [T_W-1:0] tx0_q, tz0_q;
  logic [CW_W-1:0] cwx0_q, cwz0_q;

  assign v0_d = pop_o && !item_i.is_write;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q   <= item_i.px;
      pz_q   <= item_i.pz;
      tx0_q  <= item_i.tx;
      tz0_q  <= item_i.tz;
      cwx0_q <= item_i.cwx;
      cwz0_q <= item_i.cwz;
    end
  end

  // row blend along x
  logic [NODE_W-1:0]          nw, ne, sw, se;
  logic signed [DATA_W-1:0]   htop_d, hbot_d;
  logic [CH-1:0][U_W-1:0]     top_d, bot_d;

  always_comb begin
    nw = rd_q[{pz_q, px_q}];
    ne = rd_q[{pz_q, ~px_q}];
    sw = rd_q[{~pz_q, px_q}];
    se = rd_q[{~pz_q, ~px_q}];
    htop_d = cos_blend($signed(nw[DATA_W-1:0]), $signed(ne[DATA_W-1:0]), cwx0_q);
    hbot_d = cos_blend($signed(sw[DATA_W-1:0]), $signed(se[DATA_W-1:0]), cwx0_q);
    for (int k = 0; k < CH; k++) begin
      top_d[k] = lerp_row(nw[DATA_W*(k+1) +: DATA_W], ne[DATA_W*(k+1) +: DATA_W], tx0_q);
      bot_d[k] = lerp_row(sw[DATA_W*(k+1) +: DATA_W], se[DATA_W*(k+1) +: DATA_W], tx0_q);
    end
  end

  logic                     v1_q;
  logic signed [DATA_W-1:0] htop_q, hbot_q;
  logic [CH-1:0][U_W-1:0]   top_q, bot_q;
  logic [T_W-1:0]           tz1_q;
  logic [CW_W-1:0]          cwz1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      htop_q <= htop_d;
      hbot_q <= hbot_d;
      top_q  <= top_d;
      bot_q  <= bot_d;
      tz1_q  <= tz0_q;
      cwz1_q <= cwz0_q;
    end
  end

  // column blend along z into the output register
  logic signed [DATA_W-1:0]  h_d;
  logic [CH-1:0][DATA_W-1:0] c_d;
  logic [CH-1:0][DATA_W-1:0] c_q;
  logic signed [DATA_W-1:0]  h_q;
  logic                      vo_q;

  always_comb begin
    h_d = cos_blend(htop_q, hbot_q, cwz1_q);
    for (int k = 0; k < CH; k++) c_d[k] = lerp_col(top_q[k], bot_q[k], tz1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q <= h_d;
      c_q <= c_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v0_q <= v0_d;
      v1_q <= v0_q;
      vo_q <= v1_q;
    end
  end

  assign out_valid_o      = vo_q;
  assign out_height_o     = h_q;
  assign out_vegetation_o = c_q[0];
  assign out_weight_0_o   = c_q[1];
  assign out_weight_1_o   = c_q[2];
  assign out_weight_2_o   = c_q[3];
  assign out_weight_3_o   = c_q[4];

endmodule

FILE: hdl/grid_node_sampler_unit.sv
// Samples pass the queue, bank read, row blend and output registers. Throughput: one
// beat per cycle while not stalled, writes and samples alike; each of the four node
// banks (split by row and column parity) gives one read and one write per cycle.
// Writes give no result. Reset clears the queue, pipeline valids and sets both grid
// sizes to 64; node memories are not cleared and read undefined until written.
`timescale 1ns / 1ps

module grid_node_sampler_unit import gns_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     op_i,
  input  logic [POS_W-1:0]         pos_x_i,
  input  logic [POS_W-1:0]         pos_z_i,
  input  logic [SIDE_W-1:0]        node_col_i,
  input  logic [SIDE_W-1:0]        node_row_i,
  input  logic signed [DATA_W-1:0] node_height_i,
  input  logic [DATA_W-1:0]        node_vegetation_i,
  input  logic [DATA_W-1:0]        node_weight_0_i,
  input  logic [DATA_W-1:0]        node_weight_1_i,
  input  logic [DATA_W-1:0]        node_weight_2_i,
  input  logic [DATA_W-1:0]        node_weight_3_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] out_height_o,
  output logic [DATA_W-1:0]        out_vegetation_o,
  output logic [DATA_W-1:0]        out_weight_0_o,
  output logic [DATA_W-1:0]        out_weight_1_o,
  output logic [DATA_W-1:0]        out_weight_2_o,
  output logic [DATA_W-1:0]        out_weight_3_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i
);

  function automatic logic [CFG_W-1:0] side_limit(logic [CFG_W-1:0] s);
    logic [CFG_W-1:0] e;
    if (s < CFG_W'(2))             e = CFG_W'(2);
    else if (s > CFG_W'(MAX_SIDE)) e = CFG_W'(MAX_SIDE);
    else                           e = s;
    return e - CFG_W'(2);
  endfunction

  logic [CFG_W-1:0] grid_w_q;
  logic [CFG_W-1:0] grid_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= CFG_W'(64);
      grid_h_q <= CFG_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_WIDTH:  grid_w_q <= cfg_wdata_i;
        CFG_GRID_HEIGHT: grid_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  gns_item_t front_item;
  gns_item_t queue_item;
  logic      push;
  logic      pop;
  logic      queue_valid;
  logic      queue_ready;

  gns_front u_front (
    .op_i              (op_i),
    .pos_x_i           (pos_x_i),
    .pos_z_i           (pos_z_i),
    .node_col_i        (node_col_i),
    .node_row_i        (node_row_i),
    .node_height_i     (node_height_i),
    .node_vegetation_i (node_vegetation_i),
    .node_weight_0_i   (node_weight_0_i),
    .node_weight_1_i   (node_weight_1_i),
    .node_weight_2_i   (node_weight_2_i),
    .node_weight_3_i   (node_weight_3_i),
    .limit_x_i         (side_limit(grid_w_q)),
    .limit_z_i         (side_limit(grid_h_q)),
    .item_o            (front_item)
  );

  assign in_ready_o = queue_ready;
  assign push       = in_valid_i && queue_ready;

  gns_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .ready_o (queue_ready),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  gns_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (queue_valid),
    .item_i           (queue_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_height_o     (out_height_o),
    .out_vegetation_o (out_vegetation_o),
    .out_weight_0_o   (out_weight_0_o),
    .out_weight_1_o   (out_weight_1_o),
    .out_weight_2_o   (out_weight_2_o),
    .out_weight_3_o   (out_weight_3_o)
  );

endmodule

FILE: hdl/gns_checker.sv
// Port-level checker for the node sampler, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] out_height_o,
  input logic [15:0] out_vegetation_o
);

  // a stalled result beat holds
  `GNS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `GNS_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_height_o) && $stable(out_vegetation_o), "result changed while stalled")
  // reset empties the pipeline and the queue
  `GNS_ASSERT_NR(a_rst_out, clk_i, !rst_ni |=> !out_valid_o, "result valid right after reset")
  `GNS_ASSERT_NR(a_rst_ready, clk_i, !rst_ni |=> in_ready_o, "input not ready right after reset")

endmodule

bind grid_node_sampler_unit gns_checker u_gns_checker (.*);
